// ===== hw/rtl/tpg_pkg.sv =====
// Shared constants, codes and types of the test pattern generator.
`timescale 1ns / 1ps
`default_nettype none

package tpg_pkg;

  localparam int MAX_DIM_DEFAULT = 1024;

  localparam int DIM_W     = 11;
  localparam int MODE_W    = 2;
  localparam int COLOUR_W  = 24;
  localparam int CHAN_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  localparam logic [DIM_W-1:0]    FRAME_WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0]    FRAME_HEIGHT_RST = DIM_W'(480);
  localparam logic [DIM_W-1:0]    CELL_SIZE_RST    = DIM_W'(8);
  localparam logic [COLOUR_W-1:0] COLOR_A_RST      = 24'hFFFFFF;
  localparam logic [COLOUR_W-1:0] COLOR_B_RST      = 24'h000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_PATTERN_MODE = 3'd2,
    REG_CELL_SIZE    = 3'd3,
    REG_COLOR_A      = 3'd4,
    REG_COLOR_B      = 3'd5
  } cfg_reg_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_HSTRIPE = 2'd0,
    MODE_VSTRIPE = 2'd1,
    MODE_CHECKER = 2'd2,
    MODE_SQUARES = 2'd3
  } mode_e;

  localparam mode_e PATTERN_MODE_RST = MODE_CHECKER;

  typedef struct packed {
    logic take;
    logic div_step;
    logic load_second;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
    logic two_ops;
    logic out_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tpg_if.sv =====
// Handshake channel interfaces of the test pattern generator.
`timescale 1ns / 1ps
`default_nettype none

interface tpg_req_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface tpg_pix_if;
  import tpg_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic              line_end;
  logic              frame_end;
  modport source (output valid, output red, output green, output blue,
                  output line_end, output frame_end, input ready);
  modport sink (input valid, input red, input green, input blue,
                input line_end, input frame_end, output ready);
endinterface

interface tpg_cfg_if;
  import tpg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tpg_ctrl.sv =====
// Sequencing state machine of the test pattern generator.
`timescale 1ns / 1ps
`default_nettype none

module tpg_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  tpg_req_if.sink           req_i,
  input  tpg_pkg::dp_sts_t  sts_i,
  output tpg_pkg::ctrl_cmd_t cmd_o
);
  import tpg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_A,
    ST_LOAD_B,
    ST_DIV_B,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic   ready_q;

  assign req_i.ready = ready_q;

  always_comb begin
    cmd_o             = '0;
    cmd_o.take        = ready_q & req_i.valid;
    cmd_o.div_step    = (state_q == ST_DIV_A) || (state_q == ST_DIV_B);
    cmd_o.load_second = (state_q == ST_LOAD_B);
    cmd_o.out_load    = (state_q == ST_EMIT) && !sts_i.out_busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (ready_q && req_i.valid) begin
            state_q <= ST_DIV_A;
            ready_q <= 1'b0;
          end
        end
        ST_DIV_A: begin
          if (sts_i.div_last) begin
            state_q <= sts_i.two_ops ? ST_LOAD_B : ST_EMIT;
          end
        end
        ST_LOAD_B: begin
          state_q <= ST_DIV_B;
        end
        ST_DIV_B: begin
          if (sts_i.div_last) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!sts_i.out_busy) begin
            state_q <= ST_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tpg_datapath.sv =====
// Registers, scan counters, serial divider and output register of the generator.
`timescale 1ns / 1ps
`default_nettype none

module tpg_datapath #(
  parameter int MAX_DIM = tpg_pkg::MAX_DIM_DEFAULT
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  tpg_req_if.sink            req_i,
  tpg_cfg_if.sink            cfg_i,
  tpg_pix_if.source          pix_o,
  input  tpg_pkg::ctrl_cmd_t cmd_i,
  output tpg_pkg::dp_sts_t   sts_o
);
  import tpg_pkg::*;

  localparam int DW   = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
  localparam int EW   = (DW > DIM_W) ? DW + 1 : DIM_W + 1;
  localparam int RW   = DIM_W + 1;
  localparam int CNTW = (DW > 1) ? $clog2(DW) : 1;

  logic [DIM_W-1:0]    frame_width_q;
  logic [DIM_W-1:0]    frame_height_q;
  mode_e               mode_q;
  logic [DIM_W-1:0]    cell_size_q;
  logic [COLOUR_W-1:0] color_a_q;
  logic [COLOUR_W-1:0] color_b_q;

  logic [DW-1:0] col_q, col_d;
  logic [DW-1:0] row_q, row_d;
  logic [DW-1:0] second_q;
  logic          lend_q, fend_q;

  logic [DW-1:0]   dvd_q;
  logic [RW-1:0]   rem_q;
  logic [CNTW-1:0] cnt_q;
  logic            par_q, first_par_q;

  logic                out_valid_q;
  logic [COLOUR_W-1:0] out_colour_q;
  logic                out_lend_q, out_fend_q;

  logic [DW-1:0]    last_x, last_y;
  logic [DIM_W-1:0] cs_eff;
  logic [DW-1:0]    pos_x, pos_y, right, bottom, d_min, first_op;
  logic             lend, fend;
  logic [RW-1:0]    rem_sh, rem_nx;
  logic             qbit, pick_a;

  function automatic logic [DW-1:0] last_of(input logic [DIM_W-1:0] dim);
    logic [EW-1:0] ext;
    ext = EW'(dim);
    if (dim == '0) begin
      last_of = '0;
    end else if (ext > EW'(MAX_DIM)) begin
      last_of = DW'(MAX_DIM - 1);
    end else begin
      last_of = DW'(ext - EW'(1));
    end
  endfunction

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      mode_q         <= PATTERN_MODE_RST;
      cell_size_q    <= CELL_SIZE_RST;
      color_a_q      <= COLOR_A_RST;
      color_b_q      <= COLOR_B_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_i.data[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= cfg_i.data[DIM_W-1:0];
        REG_PATTERN_MODE: mode_q         <= mode_e'(cfg_i.data[MODE_W-1:0]);
        REG_CELL_SIZE:    cell_size_q    <= cfg_i.data[DIM_W-1:0];
        REG_COLOR_A:      color_a_q      <= cfg_i.data[COLOUR_W-1:0];
        REG_COLOR_B:      color_b_q      <= cfg_i.data[COLOUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    last_x = last_of(frame_width_q);
    last_y = last_of(frame_height_q);
    cs_eff = (cell_size_q == '0) ? DIM_W'(1) : cell_size_q;
    pos_x  = req_i.restart ? '0 : col_q;
    pos_y  = req_i.restart ? '0 : row_q;
    right  = (pos_x < last_x) ? last_x - pos_x : '0;
    bottom = (pos_y < last_y) ? last_y - pos_y : '0;
    d_min  = (pos_x < pos_y) ? pos_x : pos_y;
    if (right < d_min) begin
      d_min = right;
    end
    if (bottom < d_min) begin
      d_min = bottom;
    end
    lend = (pos_x >= last_x);
    fend = lend && (pos_y >= last_y);
    case (mode_q)
      MODE_HSTRIPE: first_op = pos_y;
      MODE_VSTRIPE: first_op = pos_x;
      MODE_CHECKER: first_op = pos_x;
      MODE_SQUARES: first_op = d_min;
      default:      first_op = pos_x;
    endcase
    if (lend) begin
      col_d = '0;
      row_d = fend ? '0 : pos_y + DW'(1);
    end else begin
      col_d = pos_x + DW'(1);
      row_d = pos_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.take) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Restoring division, one quotient bit per cycle; only the quotient's
  // least significant bit is kept, as it decides the colour.
  always_comb begin
    rem_sh = {rem_q[RW-2:0], dvd_q[DW-1]};
    qbit   = (rem_sh >= RW'(cs_eff));
    rem_nx = qbit ? rem_sh - RW'(cs_eff) : rem_sh;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      dvd_q    <= first_op;
      second_q <= pos_y;
      lend_q   <= lend;
      fend_q   <= fend;
      rem_q    <= '0;
      cnt_q    <= '0;
    end else if (cmd_i.load_second) begin
      dvd_q       <= second_q;
      rem_q       <= '0;
      cnt_q       <= '0;
      first_par_q <= par_q;
    end else if (cmd_i.div_step) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_nx;
      cnt_q <= cnt_q + CNTW'(1);
      par_q <= qbit;
    end
  end

  always_comb begin
    if (mode_q == MODE_CHECKER) begin
      pick_a = (first_par_q == par_q);
    end else begin
      pick_a = !par_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (pix_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_colour_q <= pick_a ? color_a_q : color_b_q;
      out_lend_q   <= lend_q;
      out_fend_q   <= fend_q;
    end
  end

  assign pix_o.valid     = out_valid_q;
  assign pix_o.red       = out_colour_q[23:16];
  assign pix_o.green     = out_colour_q[15:8];
  assign pix_o.blue      = out_colour_q[7:0];
  assign pix_o.line_end  = out_lend_q;
  assign pix_o.frame_end = out_fend_q;

  always_comb begin
    sts_o          = '0;
    sts_o.div_last = (cnt_q == CNTW'(DW - 1));
    sts_o.two_ops  = (mode_q == MODE_CHECKER);
    sts_o.out_busy = out_valid_q && !pix_o.ready;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/test_pattern_generator_unit.sv =====
// Top level of the raster test pattern generator.
//
//   Channel  Direction  Payload                                   Transfers
//   req_i    in         restart                                   one tick per pixel
//   pix_o    out        red, green, blue, line_end, frame_end     one pixel per tick
//   cfg_i    in         index, data                               one register write
//
// Each transaction on req_i runs the serial divider, one quotient bit per cycle over
// D = clog2(MAX_DIM) bits (10 by default), once per pixel or twice in checkerboard
// mode. A new request is taken while the previous pixel still waits in the output
// register; a stalled output holds back only the final load of the next pixel.
// Reset restores the default registers and puts the scan at the origin;
// configuration writes are always taken.
`timescale 1ns / 1ps
`default_nettype none

module test_pattern_generator_unit #(
  parameter int MAX_DIM = tpg_pkg::MAX_DIM_DEFAULT
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  tpg_req_if.sink   req_i,
  tpg_pix_if.source pix_o,
  tpg_cfg_if.sink   cfg_i
);
  import tpg_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  tpg_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  tpg_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cfg_i  (cfg_i),
    .pix_o  (pix_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench of the test pattern generator: random scans checked against a pixel predictor.
`timescale 1ns / 1ps

module tb_top;
  import tpg_pkg::*;

  localparam int MAX_DIM        = MAX_DIM_DEFAULT;
  localparam int ITEM_TARGET    = 1300;
  localparam int SETTLE_CYCLES  = 30;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int IDLE_PCT       = 34;
  localparam int RESTART_PCT    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              line_end;
    logic              frame_end;
  } pixel_t;

  bit clk_i = 1'b0;
  bit rst_ni = 1'b0;

  tpg_req_if req_bus ();
  tpg_pix_if pix_bus ();
  tpg_cfg_if cfg_bus ();

  test_pattern_generator_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .pix_o  (pix_bus),
    .cfg_i  (cfg_bus)
  );

  logic [DIM_W-1:0]    frame_w     = FRAME_WIDTH_RST;
  logic [DIM_W-1:0]    frame_h     = FRAME_HEIGHT_RST;
  mode_e               scan_mode   = PATTERN_MODE_RST;
  logic [DIM_W-1:0]    cell_px     = CELL_SIZE_RST;
  logic [COLOUR_W-1:0] colour_a    = COLOR_A_RST;
  logic [COLOUR_W-1:0] colour_b    = COLOR_B_RST;
  logic [9:0]          scan_col    = '0;
  logic [9:0]          scan_row    = '0;

  bit     pending_ticks[$];
  pixel_t expected_pixels[$];
  int     items_issued  = 0;
  int     pixels_seen   = 0;
  int     error_count   = 0;
  int     stall_pct     = IDLE_PCT;
  int     quiet_cycles  = 0;
  bit     tick_taken    = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned dim_of(input logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return 32'(d);
  endfunction

  function automatic pixel_t next_pixel(input logic restart);
    int unsigned w, h, cs, last_x, last_y, right, bottom, near_d, col_u, row_u;
    logic pick_a;
    logic [COLOUR_W-1:0] colour;
    pixel_t px;
    w = dim_of(frame_w);
    h = dim_of(frame_h);
    cs = (cell_px == 0) ? 1 : 32'(cell_px);
    last_x = w - 1;
    last_y = h - 1;
    if (restart) begin
      scan_col = '0;
      scan_row = '0;
    end
    col_u = 32'(scan_col);
    row_u = 32'(scan_row);
    case (scan_mode)
      MODE_HSTRIPE: pick_a = ((row_u / cs) % 2) == 0;
      MODE_VSTRIPE: pick_a = ((col_u / cs) % 2) == 0;
      MODE_CHECKER: pick_a = ((col_u / cs) % 2) == ((row_u / cs) % 2);
      default: begin
        right = (col_u < last_x) ? last_x - col_u : 0;
        bottom = (row_u < last_y) ? last_y - row_u : 0;
        near_d = col_u;
        if (row_u < near_d) near_d = row_u;
        if (right < near_d) near_d = right;
        if (bottom < near_d) near_d = bottom;
        pick_a = ((near_d / cs) % 2) == 0;
      end
    endcase
    colour = pick_a ? colour_a : colour_b;
    px.red = colour[23:16];
    px.green = colour[15:8];
    px.blue = colour[7:0];
    px.line_end = col_u >= last_x;
    px.frame_end = px.line_end && (row_u >= last_y);
    if (px.line_end) begin
      scan_col = '0;
      scan_row = px.frame_end ? '0 : scan_row + 10'd1;
    end else begin
      scan_col = scan_col + 10'd1;
    end
    return px;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_bus.valid || tick_taken) begin
        if (pending_ticks.size() > 0 && $urandom_range(99) >= stall_pct) begin
          req_bus.valid <= 1'b1;
          req_bus.restart <= pending_ticks.pop_front();
        end else begin
          req_bus.valid <= 1'b0;
          req_bus.restart <= 1'($urandom_range(1));
        end
      end
      pix_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni) begin
      tick_taken <= req_bus.valid && req_bus.ready;
      if (pix_bus.valid && pix_bus.ready) begin
        pixels_seen++;
        if (expected_pixels.size() == 0) begin
          report_mismatch("pixel transaction with no expected pixel waiting");
        end else begin
          want = expected_pixels.pop_front();
          if (pix_bus.red !== want.red)
            report_mismatch($sformatf("red %0h, expected %0h", pix_bus.red, want.red));
          if (pix_bus.green !== want.green)
            report_mismatch($sformatf("green %0h, expected %0h", pix_bus.green, want.green));
          if (pix_bus.blue !== want.blue)
            report_mismatch($sformatf("blue %0h, expected %0h", pix_bus.blue, want.blue));
          if (pix_bus.line_end !== want.line_end)
            report_mismatch($sformatf("line_end %b, expected %b",
                                      pix_bus.line_end, want.line_end));
          if (pix_bus.frame_end !== want.frame_end)
            report_mismatch($sformatf("frame_end %b, expected %b",
                                      pix_bus.frame_end, want.frame_end));
        end
      end
      if (req_bus.valid && req_bus.ready)
        expected_pixels.push_back(next_pixel(req_bus.restart));
      if ((req_bus.valid && req_bus.ready) || (pix_bus.valid && pix_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      REG_FRAME_WIDTH:  frame_w = value[DIM_W-1:0];
      REG_FRAME_HEIGHT: frame_h = value[DIM_W-1:0];
      REG_PATTERN_MODE: scan_mode = mode_e'(value[MODE_W-1:0]);
      REG_CELL_SIZE:    cell_px = value[DIM_W-1:0];
      REG_COLOR_A:      colour_a = value[COLOUR_W-1:0];
      REG_COLOR_B:      colour_b = value[COLOUR_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic queue_tick(input bit restart);
    pending_ticks.push_back(restart);
    items_issued++;
  endtask

  task automatic drain();
    while (pixels_seen < items_issued) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [CFG_DAT_W-1:0] random_dim();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 10) return CFG_DAT_W'($urandom);
    if (roll < 15) return CFG_DAT_W'($urandom_range(MAX_DIM, MAX_DIM - 24));
    return CFG_DAT_W'($urandom_range(12, 1));
  endfunction

  function automatic logic [CFG_DAT_W-1:0] random_cell();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 10) return CFG_DAT_W'($urandom_range(2047, MAX_DIM));
    if (roll < 15) return CFG_DAT_W'($urandom);
    return CFG_DAT_W'($urandom_range(6, 1));
  endfunction

  initial begin
    int phase;
    bit all_regs;
    req_bus.valid = 1'b0;
    req_bus.restart = 1'b0;
    pix_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_FRAME_WIDTH;
    cfg_bus.data = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset geometry and colours, then a restart back to the origin.
    repeat (3) queue_tick(1'b0);
    queue_tick(1'b1);
    drain();

    // Zero dimensions and zero cell size behave as one; spare indexes are ignored.
    write_reg(REG_FRAME_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, '0);
    write_reg(REG_CELL_SIZE, '0);
    write_reg(REG_PATTERN_MODE, CFG_DAT_W'(MODE_SQUARES));
    write_reg(REG_SPARE_LO, CFG_DAT_W'($urandom));
    write_reg(REG_SPARE_HI, CFG_DAT_W'($urandom));
    queue_tick(1'b0);
    queue_tick(1'b1);
    drain();

    // Oversized width is clamped to the maximum; extreme colours.
    write_reg(REG_FRAME_WIDTH, '1);
    write_reg(REG_FRAME_HEIGHT, CFG_DAT_W'(3));
    write_reg(REG_PATTERN_MODE, CFG_DAT_W'(MODE_VSTRIPE));
    write_reg(REG_CELL_SIZE, CFG_DAT_W'(1));
    write_reg(REG_COLOR_A, '0);
    write_reg(REG_COLOR_B, '1);
    queue_tick(1'b0);
    queue_tick(1'b0);
    queue_tick(1'b1);
    drain();

    // A cell wider than the frame always selects the first colour.
    write_reg(REG_FRAME_WIDTH, CFG_DAT_W'(4));
    write_reg(REG_FRAME_HEIGHT, CFG_DAT_W'(2));
    write_reg(REG_CELL_SIZE, CFG_DAT_W'(2047));
    write_reg(REG_PATTERN_MODE, CFG_DAT_W'(MODE_HSTRIPE));
    repeat (4) queue_tick(1'b0);
    drain();

    // The frame shrinks beneath the scan position part way through a line.
    write_reg(REG_FRAME_WIDTH, CFG_DAT_W'(8));
    write_reg(REG_FRAME_HEIGHT, CFG_DAT_W'(8));
    write_reg(REG_CELL_SIZE, CFG_DAT_W'(2));
    write_reg(REG_PATTERN_MODE, CFG_DAT_W'(MODE_CHECKER));
    repeat (5) queue_tick(1'b0);
    drain();
    write_reg(REG_FRAME_WIDTH, CFG_DAT_W'(3));
    write_reg(REG_PATTERN_MODE, CFG_DAT_W'(MODE_SQUARES));
    repeat (3) queue_tick(1'b0);
    drain();

    phase = 0;
    while (items_issued < ITEM_TARGET) begin
      stall_pct = (phase == 6) ? 0 : IDLE_PCT;
      all_regs = (phase % 8) == 0;
      if (all_regs || $urandom_range(1)) write_reg(REG_FRAME_WIDTH, random_dim());
      if (all_regs || $urandom_range(1)) write_reg(REG_FRAME_HEIGHT, random_dim());
      if (all_regs || $urandom_range(1)) write_reg(REG_PATTERN_MODE, CFG_DAT_W'($urandom));
      if (all_regs || $urandom_range(1)) write_reg(REG_CELL_SIZE, random_cell());
      if (all_regs || $urandom_range(1)) write_reg(REG_COLOR_A, CFG_DAT_W'($urandom));
      if (all_regs || $urandom_range(1)) write_reg(REG_COLOR_B, CFG_DAT_W'($urandom));
      repeat ((phase == 6) ? 150 : $urandom_range(90, 20))
        queue_tick($urandom_range(99) < RESTART_PCT);
      drain();
      phase++;
    end

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tpg_pkg.sv
hw/rtl/tpg_if.sv
hw/rtl/tpg_ctrl.sv
hw/rtl/tpg_datapath.sv
hw/rtl/test_pattern_generator_unit.sv
tb/tb_top.sv
